>>> design/mstt_pkg.sv
package mstt_pkg;

	localparam int unsigned ACTION_W = 2;
	localparam int unsigned PERIOD_W = 32;
	localparam int unsigned TAG_IN_W = 16;
	localparam int unsigned SLOT_ID_W = 6;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned SLOT_OUT_W = 5;
	localparam int unsigned STEP_W = 16;
	localparam logic [STEP_W-1:0] STEP_RESET = 16'd100;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK = 2'd0,
		ACT_SET = 2'd1,
		ACT_CANCEL = 2'd2
	} action_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SET_OK = 3'd0,
		KIND_SET_FULL = 3'd1,
		KIND_CANCEL_DONE = 3'd2,
		KIND_FIRED = 3'd3,
		KIND_TICK_DONE = 3'd4
	} kind_t;

	// Command fields broadcast to every cell.
	typedef struct packed {
		logic set;
		logic tick;
		logic cancel;
		logic [PERIOD_W-1:0] period;
		logic repeat_req;
		logic [TAG_IN_W-1:0] user_tag;
		logic [SLOT_ID_W-1:0] slot_id;
		logic [STEP_W-1:0] step;
	} cmd_t;

	// Token handed from cell to cell during a walk.
	typedef struct packed {
		logic valid;
		logic taken;
		logic [SLOT_ID_W-1:0] slot;
	} tok_t;

	// Fire event of the cell that holds the token.
	typedef struct packed {
		logic fire;
		logic [TAG_IN_W-1:0] tag;
	} evt_t;

endpackage

>>> design/mstt_req_if.sv
interface mstt_req_if;
	logic valid;
	logic ready;
	logic [mstt_pkg::ACTION_W-1:0] action;
	logic [mstt_pkg::PERIOD_W-1:0] period;
	logic repeat_req;
	logic [mstt_pkg::TAG_IN_W-1:0] user_tag;
	logic [mstt_pkg::SLOT_ID_W-1:0] slot_id;

	modport source (output valid, action, period, repeat_req, user_tag, slot_id, input ready);
	modport sink (input valid, action, period, repeat_req, user_tag, slot_id, output ready);
endinterface

>>> design/mstt_rsp_if.sv
interface mstt_rsp_if;
	logic valid;
	logic ready;
	logic [mstt_pkg::KIND_W-1:0] kind;
	logic [mstt_pkg::SLOT_OUT_W-1:0] slot;
	logic [mstt_pkg::TAG_IN_W-1:0] tag_out;
	logic last;

	modport source (output valid, kind, slot, tag_out, last, input ready);
	modport sink (input valid, kind, slot, tag_out, last, output ready);
endinterface

>>> design/mstt_cfg_if.sv
interface mstt_cfg_if;
	logic valid;
	logic ready;
	logic [mstt_pkg::STEP_W-1:0] tick_step;

	modport source (output valid, tick_step, input ready);
	modport sink (input valid, tick_step, output ready);
endinterface

>>> design/mstt_cell.sv
module mstt_cell #(
	parameter int CELL_IDX = 0,
	parameter int TAG_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input mstt_pkg::cmd_t cmd,
	input mstt_pkg::tok_t tok_in,
	output mstt_pkg::tok_t tok_out,
	output mstt_pkg::evt_t evt
);

	localparam logic [mstt_pkg::SLOT_ID_W-1:0] IDX = mstt_pkg::SLOT_ID_W'(CELL_IDX);

	logic [mstt_pkg::PERIOD_W-1:0] period_q;
	logic [mstt_pkg::PERIOD_W-1:0] count_q;
	logic repeat_q;
	logic [TAG_BITS-1:0] tag_q;
	mstt_pkg::tok_t tok_q;

	logic here;
	logic active;
	logic [mstt_pkg::PERIOD_W:0] sum;
	logic fire;
	logic alloc;

	assign here = tok_q.valid;
	assign active = (period_q != '0);
	assign sum = {1'b0, count_q} + (mstt_pkg::PERIOD_W+1)'(cmd.step);
	assign fire = here && cmd.tick && active && (sum >= {1'b0, period_q});
	assign alloc = here && cmd.set && !tok_q.taken && !active;

	assign tok_out.valid = tok_q.valid;
	assign tok_out.taken = tok_q.taken | alloc;
	assign tok_out.slot = alloc ? IDX : tok_q.slot;

	assign evt.fire = fire;
	assign evt.tag = fire ? mstt_pkg::TAG_IN_W'(tag_q) : '0;

	// Token and free/active marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			period_q <= '0;
		end else begin
			if (adv) begin
				tok_q <= tok_in;
			end
			if (cmd.cancel && (cmd.slot_id == IDX)) begin
				period_q <= '0;
			end else if (adv && alloc) begin
				period_q <= cmd.period;
			end else if (adv && fire && !repeat_q) begin
				period_q <= '0;
			end
		end
	end

	// Slot payload
	always_ff @(posedge clk) begin
		if (adv && alloc) begin
			count_q <= '0;
			repeat_q <= cmd.repeat_req;
			tag_q <= TAG_BITS'(cmd.user_tag);
		end else if (adv && here && cmd.tick && active) begin
			count_q <= fire ? '0 : sum[mstt_pkg::PERIOD_W-1:0];
		end
	end

endmodule

>>> design/multi_slot_timer_table.sv
// Channel | Dir | Payload                                     | Handshake
// req     | in  | action, period, repeat_req, user_tag, slot_id | valid/ready
// rsp     | out | kind, slot, tag_out, last                   | valid/ready
// cfg     | in  | tick_step                                   | valid/ready
//
// Actions: a cancel is answered without a walk; a set or a tick walks one token down the
// row of slot cells, one cell per cycle unless a firing cell finds the response register
// busy, and closes with a last response.
// Reset: arst_n clears every slot to free, tick_step to 100, and the FSM to idle.
// Stalls: a firing cell holds the walk until the response register is free;
// req is taken only in idle with the response register free to take a transaction.
module multi_slot_timer_table_core #(
	parameter int SLOT_COUNT = 32,
	parameter int TAG_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	mstt_req_if.sink req,
	mstt_rsp_if.source rsp,
	mstt_cfg_if.sink cfg
);

	localparam logic [mstt_pkg::SLOT_ID_W-1:0] LAST_POS =
		mstt_pkg::SLOT_ID_W'(SLOT_COUNT - 1);
	localparam logic [mstt_pkg::SLOT_ID_W:0] SLOT_LIM =
		(mstt_pkg::SLOT_ID_W+1)'(SLOT_COUNT);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH
	} state_t;

	state_t state_q;
	logic [mstt_pkg::SLOT_ID_W-1:0] pos_q;
	logic [mstt_pkg::STEP_W-1:0] step_q;

	// Held command of the walk in progress
	mstt_pkg::action_t act_q;
	logic [mstt_pkg::PERIOD_W-1:0] period_q;
	logic repeat_q;
	logic [mstt_pkg::TAG_IN_W-1:0] tag_q;
	logic fin_taken_q;
	logic [mstt_pkg::SLOT_ID_W-1:0] fin_slot_q;

	// Response register
	logic out_valid_q;
	mstt_pkg::kind_t out_kind_q;
	logic [mstt_pkg::SLOT_OUT_W-1:0] out_slot_q;
	logic [mstt_pkg::TAG_IN_W-1:0] out_tag_q;
	logic out_last_q;

	logic out_free;
	logic out_load;
	logic req_acc;
	mstt_pkg::action_t req_act;
	logic start;
	logic adv;
	logic cell_adv;
	logic fire_any;
	logic [mstt_pkg::TAG_IN_W-1:0] fire_tag;
	logic [SLOT_COUNT-1:0] tok_vec;
	logic [SLOT_COUNT-1:0] fire_vec;

	mstt_pkg::cmd_t cmd;
	mstt_pkg::tok_t tok_chain [0:SLOT_COUNT];
	mstt_pkg::evt_t evt [0:SLOT_COUNT-1];

	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign req_acc = req.valid && req.ready;
	assign req_act = mstt_pkg::action_t'(req.action);
	assign start = req_acc && ((req_act == mstt_pkg::ACT_SET) || (req_act == mstt_pkg::ACT_TICK));

	// Advance the walk unless a firing cell finds the response register busy.
	assign adv = (state_q == S_WALK) && (!fire_any || out_free);
	assign cell_adv = adv || start;

	// Load the response register with a cancel result, a fire or a walk's closing result.
	assign out_load = (req_acc && (req_act == mstt_pkg::ACT_CANCEL)) ||
		(adv && fire_any) || ((state_q == S_FINISH) && out_free);

	assign cfg.ready = 1'b1;

	assign rsp.valid = out_valid_q;
	assign rsp.kind = out_kind_q;
	assign rsp.slot = out_slot_q;
	assign rsp.tag_out = out_tag_q;
	assign rsp.last = out_last_q;

	always_comb begin
		cmd.set = (act_q == mstt_pkg::ACT_SET);
		cmd.tick = (act_q == mstt_pkg::ACT_TICK);
		cmd.cancel = req_acc && (req_act == mstt_pkg::ACT_CANCEL);
		cmd.period = period_q;
		cmd.repeat_req = repeat_q;
		cmd.user_tag = tag_q;
		cmd.slot_id = req.slot_id;
		cmd.step = step_q;
	end

	// Inject a fresh token into the first cell on start.
	always_comb begin
		tok_chain[0].valid = start;
		tok_chain[0].taken = 1'b0;
		tok_chain[0].slot = '0;
	end

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		mstt_cell #(
			.CELL_IDX(i),
			.TAG_BITS(TAG_BITS)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(cell_adv),
			.cmd(cmd),
			.tok_in(tok_chain[i]),
			.tok_out(tok_chain[i+1]),
			.evt(evt[i])
		);
		assign tok_vec[i] = tok_chain[i+1].valid;
		assign fire_vec[i] = evt[i].fire;
	end

	// Only the cell holding the token can fire, so an OR picks its event.
	always_comb begin
		fire_tag = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			fire_tag = fire_tag | evt[i].tag;
		end
	end
	assign fire_any = |fire_vec;

	// Tick step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mstt_pkg::STEP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			step_q <= cfg.tick_step;
		end
	end

	// Sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q <= '0;
			act_q <= mstt_pkg::ACT_TICK;
			period_q <= '0;
			repeat_q <= 1'b0;
			tag_q <= '0;
			fin_taken_q <= 1'b0;
			fin_slot_q <= '0;
			out_valid_q <= 1'b0;
			out_kind_q <= mstt_pkg::KIND_SET_OK;
			out_slot_q <= '0;
			out_tag_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			// Drop the response once it is taken, unless a new one loads below.
			if (rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						act_q <= req_act;
						period_q <= req.period;
						repeat_q <= req.repeat_req;
						tag_q <= req.user_tag;
						pos_q <= '0;
						case (req_act)
							mstt_pkg::ACT_SET, mstt_pkg::ACT_TICK: begin
								state_q <= S_WALK;
							end
							mstt_pkg::ACT_CANCEL: begin
								out_valid_q <= 1'b1;
								out_kind_q <= mstt_pkg::KIND_CANCEL_DONE;
								out_slot_q <= ({1'b0, req.slot_id} < SLOT_LIM) ?
									req.slot_id[mstt_pkg::SLOT_OUT_W-1:0] : '0;
								out_tag_q <= '0;
								out_last_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				S_WALK: begin
					if (adv) begin
						if (fire_any) begin
							out_valid_q <= 1'b1;
							out_kind_q <= mstt_pkg::KIND_FIRED;
							out_slot_q <= pos_q[mstt_pkg::SLOT_OUT_W-1:0];
							out_tag_q <= fire_tag;
							out_last_q <= 1'b0;
						end
						if (pos_q == LAST_POS) begin
							fin_taken_q <= tok_chain[SLOT_COUNT].taken;
							fin_slot_q <= tok_chain[SLOT_COUNT].slot;
							state_q <= S_FINISH;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_tag_q <= '0;
						out_last_q <= 1'b1;
						if (act_q == mstt_pkg::ACT_SET) begin
							out_kind_q <= fin_taken_q ? mstt_pkg::KIND_SET_OK :
								mstt_pkg::KIND_SET_FULL;
							out_slot_q <= fin_taken_q ?
								fin_slot_q[mstt_pkg::SLOT_OUT_W-1:0] : '0;
						end else begin
							out_kind_q <= mstt_pkg::KIND_TICK_DONE;
							out_slot_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Exactly one token travels the row during a walk.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> $onehot(tok_vec))
		else $error("token count wrong during walk");

	// No token remains outside a walk.
	a_no_token_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_WALK) |-> (tok_vec == '0))
		else $error("stray token outside walk");

	// At most one cell fires in a cycle.
	a_single_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(fire_vec))
		else $error("several cells fired at once");

	// A fire blocked by a busy response register holds the walk position.
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_WALK) && fire_any && !out_free) |=> $stable(pos_q))
		else $error("walk advanced past a blocked fire");

	// The closing response of a walk always carries last.
	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FINISH) && out_free) |=> (out_valid_q && out_last_q))
		else $error("walk closed without a last response");

endmodule

>>> tb/sv/tb_multi_slot_timer_table_core.sv
`timescale 1ns / 1ps

module tb_multi_slot_timer_table_core;

	localparam int SLOTS = 32;
	localparam int TAGW = 16;
	// Action code with no meaning: the block must drop it without a result.
	localparam logic [mstt_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
	// Idle cycles after the last result before a register write or the end.
	localparam int SETTLE_CYCLES = 48;
	localparam int HOLD_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	typedef struct {
		logic [mstt_pkg::ACTION_W-1:0] action;
		logic [mstt_pkg::PERIOD_W-1:0] period;
		logic repeat_req;
		logic [mstt_pkg::TAG_IN_W-1:0] user_tag;
		logic [mstt_pkg::SLOT_ID_W-1:0] slot_id;
	} timer_req_t;

	typedef struct {
		mstt_pkg::kind_t kind;
		logic [mstt_pkg::SLOT_OUT_W-1:0] slot;
		logic [mstt_pkg::TAG_IN_W-1:0] tag_out;
		logic last;
	} timer_rsp_t;

	logic clk;
	logic arst_n;

	mstt_req_if req_ch ();
	mstt_rsp_if rsp_ch ();
	mstt_cfg_if cfg_ch ();

	multi_slot_timer_table_core #(
		.SLOT_COUNT(SLOTS),
		.TAG_BITS(TAGW)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// Shadow copy of the timer table, updated in acceptance order.
	logic [mstt_pkg::PERIOD_W-1:0] tmr_period [SLOTS];
	logic [mstt_pkg::PERIOD_W-1:0] tmr_count [SLOTS];
	logic tmr_reload [SLOTS];
	logic [mstt_pkg::TAG_IN_W-1:0] tmr_tag [SLOTS];
	logic [mstt_pkg::STEP_W-1:0] step_now;

	timer_req_t pend_req[$];	// requests not yet offered to the block
	timer_rsp_t due_rsp[$];		// results owed by the block, oldest first

	int unsigned mismatches = 0;
	int unsigned req_taken_n = 0;	// bumped by the monitor on each request transaction
	int unsigned req_taken_seen = 0;
	int unsigned send_gap = 0;
	int unsigned rcv_gap = 0;
	int unsigned cycles = 0;
	bit calm = 0;		// no idling on either side
	bit hold_arm = 0;
	bit hold_active = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Queue one result that the block owes.
	function automatic void owe_result(mstt_pkg::kind_t k, int s,
			logic [mstt_pkg::TAG_IN_W-1:0] t, logic l);
		timer_rsp_t r;
		r.kind = k;
		r.slot = s[mstt_pkg::SLOT_OUT_W-1:0];
		r.tag_out = t;
		r.last = l;
		due_rsp.push_back(r);
	endfunction

	// Apply one accepted request to the shadow table and record its results.
	function automatic void timer_table_apply(timer_req_t r);
		logic [mstt_pkg::PERIOD_W:0] sum;
		int free_slot;
		free_slot = -1;
		case (r.action)
			mstt_pkg::ACT_SET: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (free_slot < 0 && tmr_period[i] == '0)
						free_slot = i;
				end
				if (free_slot >= 0) begin
					// A zero period is reported as allocated but leaves the slot free.
					tmr_period[free_slot] = r.period;
					tmr_count[free_slot] = '0;
					tmr_reload[free_slot] = r.repeat_req;
					tmr_tag[free_slot] = r.user_tag;
					owe_result(mstt_pkg::KIND_SET_OK, free_slot, '0, 1'b1);
				end else begin
					owe_result(mstt_pkg::KIND_SET_FULL, 0, '0, 1'b1);
				end
			end
			mstt_pkg::ACT_CANCEL: begin
				// Out-of-range slot numbers change nothing and report slot 0.
				if (r.slot_id < SLOTS) begin
					tmr_period[r.slot_id] = '0;
					owe_result(mstt_pkg::KIND_CANCEL_DONE, int'(r.slot_id), '0, 1'b1);
				end else begin
					owe_result(mstt_pkg::KIND_CANCEL_DONE, 0, '0, 1'b1);
				end
			end
			mstt_pkg::ACT_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (tmr_period[i] != '0) begin
						// Compare at 33 bits so the sum never wraps.
						sum = {1'b0, tmr_count[i]} +
							{{(mstt_pkg::PERIOD_W + 1 - mstt_pkg::STEP_W){1'b0}}, step_now};
						if (sum >= {1'b0, tmr_period[i]}) begin
							tmr_count[i] = '0;
							owe_result(mstt_pkg::KIND_FIRED, i, tmr_tag[i], 1'b0);
							if (!tmr_reload[i])
								tmr_period[i] = '0;
						end else begin
							tmr_count[i] = sum[mstt_pkg::PERIOD_W-1:0];
						end
					end
				end
				owe_result(mstt_pkg::KIND_TICK_DONE, 0, '0, 1'b1);
			end
			default: begin
				// unused code: drop it
			end
		endcase
	endfunction

	function automatic void check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Monitor: sample both channels at the rising edge. Check results first,
	// since a result can never belong to a request taken at the same edge.
	always @(posedge clk) begin
		timer_rsp_t want;
		timer_req_t got_req;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_rsp.size() == 0) begin
					$error("unexpected result: kind %0d slot %0d tag_out %0d last %0d",
						rsp_ch.kind, rsp_ch.slot, rsp_ch.tag_out, rsp_ch.last);
					mismatches++;
				end else begin
					want = due_rsp.pop_front();
					check_field("kind", 64'(want.kind), 64'(rsp_ch.kind));
					check_field("slot", 64'(want.slot), 64'(rsp_ch.slot));
					check_field("tag_out", 64'(want.tag_out), 64'(rsp_ch.tag_out));
					check_field("last", 64'(want.last), 64'(rsp_ch.last));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				got_req.action = req_ch.action;
				got_req.period = req_ch.period;
				got_req.repeat_req = req_ch.repeat_req;
				got_req.user_tag = req_ch.user_tag;
				got_req.slot_id = req_ch.slot_id;
				timer_table_apply(got_req);
				req_taken_n++;
			end
		end
	end

	// Request driver: advance to the next pending request once the current
	// transaction has gone through; insert random gaps unless calm.
	always @(negedge clk) begin
		timer_req_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken_n != req_taken_seen) begin
			req_taken_seen = req_taken_n;
			if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (pend_req.size() > 0) begin
				if (!calm && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(1, 14) - 1;
					req_ch.valid <= 1'b0;
				end else begin
					nxt = pend_req.pop_front();
					req_ch.action <= nxt.action;
					req_ch.period <= nxt.period;
					req_ch.repeat_req <= nxt.repeat_req;
					req_ch.user_tag <= nxt.user_tag;
					req_ch.slot_id <= nxt.slot_id;
					req_ch.valid <= 1'b1;
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Result side: random stall bursts, plus the long hold-off when armed.
	always @(negedge clk) begin
		if (rcv_gap > 0)
			rcv_gap--;
		else if (!calm && $urandom_range(0, 4) == 0)
			rcv_gap = $urandom_range(1, 14);
		rsp_ch.ready <= !(hold_active || rcv_gap > 0);
	end

	// Long hold-off: hold ready low while the sender keeps offering, so the
	// result register fills and the block stops taking requests.
	initial begin
		wait (hold_arm);
		@(posedge clk);
		hold_active = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_multi_slot_timer_table_core NOT OK");
			$finish;
		end
	end

	task automatic queue_req(logic [mstt_pkg::ACTION_W-1:0] action,
			logic [mstt_pkg::PERIOD_W-1:0] period, logic rep,
			logic [mstt_pkg::TAG_IN_W-1:0] tag, logic [mstt_pkg::SLOT_ID_W-1:0] sid);
		timer_req_t r;
		r.action = action;
		r.period = period;
		r.repeat_req = rep;
		r.user_tag = tag;
		r.slot_id = sid;
		pend_req.push_back(r);
	endtask

	// Period that fires within a few ticks at the given step, now and then zero.
	function automatic logic [mstt_pkg::PERIOD_W-1:0] short_period(int unsigned step);
		longint unsigned p;
		case ($urandom_range(0, 9))
			0: p = 0;
			1, 2: p = 64'(step);
			3, 4, 5: p = 64'($urandom_range(1, step));
			6, 7: p = 64'($urandom_range(step, 4 * step));
			default: p = 64'(step) * 64'($urandom_range(2, 3)) + 64'd1;
		endcase
		return p[mstt_pkg::PERIOD_W-1:0];
	endfunction

	// Mostly well-formed runs: sets followed by ticks, cancels of the low
	// slots, and an occasional fill of the whole table; the rest is noise.
	task automatic queue_traffic(int n_items, int unsigned step);
		int made;
		int pick;
		int k;
		logic [mstt_pkg::SLOT_ID_W-1:0] sid;
		logic [mstt_pkg::ACTION_W-1:0] act;
		made = 0;
		while (made < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				k = $urandom_range(1, 5);
				for (int i = 0; i < k; i++)
					queue_req(mstt_pkg::ACT_SET, short_period(step),
						1'($urandom_range(0, 1)),
						mstt_pkg::TAG_IN_W'($urandom_range(0, 65535)),
						mstt_pkg::SLOT_ID_W'($urandom_range(0, 63)));
				made += k;
				k = $urandom_range(1, 6);
				for (int i = 0; i < k; i++)
					queue_req(mstt_pkg::ACT_TICK, $urandom, 1'($urandom_range(0, 1)),
						mstt_pkg::TAG_IN_W'($urandom_range(0, 65535)),
						mstt_pkg::SLOT_ID_W'($urandom_range(0, 63)));
				made += k;
			end else if (pick < 75) begin
				k = $urandom_range(1, 3);
				for (int i = 0; i < k; i++) begin
					sid = ($urandom_range(0, 9) == 0) ?
						mstt_pkg::SLOT_ID_W'($urandom_range(SLOTS, 63)) :
						mstt_pkg::SLOT_ID_W'($urandom_range(0, 15));
					queue_req(mstt_pkg::ACT_CANCEL, $urandom, 1'($urandom_range(0, 1)),
						mstt_pkg::TAG_IN_W'($urandom_range(0, 65535)), sid);
				end
				queue_req(mstt_pkg::ACT_TICK, '0, 1'b0, '0, '0);
				made += k + 1;
			end else if (pick < 79) begin
				// One set more than the table holds forces a full report; the
				// short periods make the following tick fire every slot these sets fill.
				for (int i = 0; i <= SLOTS; i++)
					queue_req(mstt_pkg::ACT_SET, $urandom_range(1, step),
						1'($urandom_range(0, 1)),
						mstt_pkg::TAG_IN_W'($urandom_range(0, 65535)), '0);
				queue_req(mstt_pkg::ACT_TICK, '0, 1'b0, '0, '0);
				queue_req(mstt_pkg::ACT_TICK, '0, 1'b0, '0, '0);
				made += SLOTS + 3;
			end else begin
				act = mstt_pkg::ACTION_W'($urandom_range(0, 3));
				queue_req(act, $urandom, 1'($urandom_range(0, 1)),
					mstt_pkg::TAG_IN_W'($urandom_range(0, 65535)),
					mstt_pkg::SLOT_ID_W'($urandom_range(0, 63)));
				if (act != ACT_UNUSED)
					made++;
			end
		end
	endtask

	// Wait until every request is taken and every result is in, then let
	// the block sit idle before the next step of the test.
	task automatic settle();
		while (pend_req.size() != 0 || req_ch.valid || due_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tick_step(logic [mstt_pkg::STEP_W-1:0] value);
		@(negedge clk);
		cfg_ch.tick_step <= value;
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		step_now = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.action = mstt_pkg::ACT_TICK;
		req_ch.period = '0;
		req_ch.repeat_req = 1'b0;
		req_ch.user_tag = '0;
		req_ch.slot_id = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.tick_step = '0;
		step_now = mstt_pkg::STEP_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			tmr_period[i] = '0;
			tmr_count[i] = '0;
			tmr_reload[i] = 1'b0;
			tmr_tag[i] = '0;
		end
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening at the reset step of 100.
		queue_req(mstt_pkg::ACT_TICK, '0, 1'b0, '0, '0);			// empty table
		queue_req(mstt_pkg::ACT_SET, 32'd100, 1'b1, 16'hFFFF, '0);	// slot 0, repeating
		queue_req(mstt_pkg::ACT_SET, 32'd0, 1'b1, 16'h0000, 6'd63);	// zero period stays free
		queue_req(mstt_pkg::ACT_SET, 32'd250, 1'b0, 16'h1234, '0);	// slot 1, one-shot
		queue_req(mstt_pkg::ACT_SET, 32'hFFFF_FFFF, 1'b1, 16'h0000, '0);	// largest period
		queue_req(mstt_pkg::ACT_TICK, '0, 1'b0, '0, '0);
		queue_req(mstt_pkg::ACT_TICK, '0, 1'b0, '0, '0);
		queue_req(mstt_pkg::ACT_TICK, '0, 1'b0, '0, '0);			// one-shot fires and frees
		queue_req(mstt_pkg::ACT_CANCEL, '0, 1'b0, '0, 6'd63);		// out of range
		queue_req(mstt_pkg::ACT_CANCEL, '0, 1'b0, '0, 6'd32);		// first out-of-range number
		queue_req(mstt_pkg::ACT_CANCEL, '0, 1'b0, '0, 6'd1);		// already free
		queue_req(ACT_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 6'd63);
		queue_req(mstt_pkg::ACT_CANCEL, '0, 1'b0, '0, 6'd2);
		queue_req(mstt_pkg::ACT_CANCEL, '0, 1'b0, '0, 6'd0);
		queue_req(mstt_pkg::ACT_TICK, '0, 1'b0, '0, '0);			// nothing active
		queue_req(mstt_pkg::ACT_SET, 32'd1, 1'b0, 16'h8000, '0);
		queue_req(mstt_pkg::ACT_SET, 32'h8000_0000, 1'b0, 16'h7FFF, '0);
		queue_req(mstt_pkg::ACT_TICK, '0, 1'b0, '0, '0);
		queue_req(mstt_pkg::ACT_CANCEL, '0, 1'b0, '0, 6'd31);
		queue_req(mstt_pkg::ACT_CANCEL, '0, 1'b0, '0, 6'd1);
		settle();

		// Largest step.
		write_tick_step(16'hFFFF);
		queue_traffic(60, 65535);
		settle();

		// Smallest step, with the long hold-off on the result side.
		write_tick_step(16'd1);
		queue_traffic(50, 1);
		hold_arm = 1'b1;
		settle();

		write_tick_step(mstt_pkg::STEP_W'($urandom_range(2, 300)));
		queue_traffic(60, 32'(step_now));
		settle();

		write_tick_step(mstt_pkg::STEP_W'($urandom_range(1, 65535)));
		queue_traffic(60, 32'(step_now));
		settle();

		// Final stretch with both sides running flat out.
		write_tick_step(mstt_pkg::STEP_W'($urandom_range(50, 2000)));
		calm = 1'b1;
		queue_traffic(60, 32'(step_now));
		settle();

		if (mismatches == 0)
			$display("tb_multi_slot_timer_table_core OK");
		else
			$display("tb_multi_slot_timer_table_core NOT OK");
		$finish;
	end

endmodule

>>> multi_slot_timer_table_core.f
design/mstt_pkg.sv
design/mstt_req_if.sv
design/mstt_rsp_if.sv
design/mstt_cfg_if.sv
design/mstt_cell.sv
design/multi_slot_timer_table.sv
tb/sv/tb_multi_slot_timer_table_core.sv
